// File: design/assert_macros.svh
// assertion macros for the design files, included by the top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: design/psc_pkg.sv
// types and constants of the pad stick and trigger conditioner
// no dependencies
`timescale 1ns / 1ps
package psc_pkg;
  localparam int DivSteps = 7;
  // magnitude, products, side select, numerators, divider, sign restore
  localparam int Stages = DivSteps + 5;

  typedef enum logic [2:0] {
    REG_DEAD_ZONE       = 3'd0,
    REG_OUTER_X         = 3'd1,
    REG_OUTER_Y         = 3'd2,
    REG_CORNER_X        = 3'd3,
    REG_CORNER_Y        = 3'd4,
    REG_TRIGGER_FLOOR   = 3'd5,
    REG_TRIGGER_CEILING = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] dead_zone;
    logic [6:0] outer_x;
    logic [6:0] outer_y;
    logic [6:0] corner_x;
    logic [6:0] corner_y;
    logic [7:0] trigger_floor;
    logic [7:0] trigger_ceiling;
  } cfg_t;
endpackage

// File: design/psc_ifs.sv
// request channel interfaces: input report, result, register write
// uses no package
`timescale 1ns / 1ps
interface psc_in_if;
  logic valid;
  logic ready;
  logic pad_error;
  logic signed [7:0] main_x;
  logic signed [7:0] main_y;
  logic signed [7:0] sub_x;
  logic signed [7:0] sub_y;
  logic [7:0] left_trigger;
  logic [7:0] right_trigger;
  modport source (output valid, pad_error, main_x, main_y, sub_x, sub_y,
                  left_trigger, right_trigger, input ready);
  modport sink (input valid, pad_error, main_x, main_y, sub_x, sub_y,
                left_trigger, right_trigger, output ready);
endinterface

interface psc_out_if;
  logic valid;
  logic ready;
  logic signed [7:0] main_x_out;
  logic signed [7:0] main_y_out;
  logic signed [7:0] sub_x_out;
  logic signed [7:0] sub_y_out;
  logic [7:0] left_trigger_out;
  logic [7:0] right_trigger_out;
  modport source (output valid, main_x_out, main_y_out, sub_x_out, sub_y_out,
                  left_trigger_out, right_trigger_out, input ready);
  modport sink (input valid, main_x_out, main_y_out, sub_x_out, sub_y_out,
                left_trigger_out, right_trigger_out, output ready);
endinterface

interface psc_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/psc_cfg.sv
// configuration register file
// depends on psc_pkg and psc_ifs
`timescale 1ns / 1ps
module psc_cfg (
  input  logic clk,
  input  logic rst,
  psc_cfg_if.sink cfg,
  output psc_pkg::cfg_t regs
);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dead_zone       <= 7'd15;
      regs.outer_x         <= 7'd74;
      regs.outer_y         <= 7'd74;
      regs.corner_x        <= 7'd52;
      regs.corner_y        <= 7'd52;
      regs.trigger_floor   <= 8'd40;
      regs.trigger_ceiling <= 8'd210;
    end else if (cfg.valid) begin
      case (cfg.index)
        psc_pkg::REG_DEAD_ZONE:       regs.dead_zone       <= cfg.data[6:0];
        psc_pkg::REG_OUTER_X:         regs.outer_x         <= cfg.data[6:0];
        psc_pkg::REG_OUTER_Y:         regs.outer_y         <= cfg.data[6:0];
        psc_pkg::REG_CORNER_X:        regs.corner_x        <= cfg.data[6:0];
        psc_pkg::REG_CORNER_Y:        regs.corner_y        <= cfg.data[6:0];
        psc_pkg::REG_TRIGGER_FLOOR:   regs.trigger_floor   <= cfg.data;
        psc_pkg::REG_TRIGGER_CEILING: regs.trigger_ceiling <= cfg.data;
        default: ;
      endcase
    end
  end
endmodule

// File: design/psc_stick.sv
// one stick: dead zone, octagon test, pipelined divider, sign restore
// depends on psc_pkg
`timescale 1ns / 1ps
module psc_stick (
  input  logic clk,
  input  logic en,
  input  psc_pkg::cfg_t regs,
  input  logic signed [7:0] x,
  input  logic signed [7:0] y,
  output logic signed [7:0] x_out,
  output logic signed [7:0] y_out
);
  localparam int N = psc_pkg::DivSteps;

  // stage 1: magnitude less dead zone
  logic [7:0] ax, ay;
  logic [7:0] mx1, my1;
  logic nx1, ny1;
  assign ax = x[7] ? 8'(-x) : 8'(x);
  assign ay = y[7] ? 8'(-y) : 8'(y);
  always_ff @(posedge clk) begin
    if (en) begin
      mx1 <= (ax > {1'b0, regs.dead_zone}) ? ax - {1'b0, regs.dead_zone} : 8'd0;
      my1 <= (ay > {1'b0, regs.dead_zone}) ? ay - {1'b0, regs.dead_zone} : 8'd0;
      nx1 <= x[7];
      ny1 <= y[7];
    end
  end

  // stage 2: products
  logic [14:0] cymx2, cxmy2;
  logic signed [16:0] qa2, qb2;
  logic [13:0] la2, lb2;
  logic [7:0] mx2, my2;
  logic nx2, ny2;
  logic signed [7:0] dxo, dyo;
  assign dxo = $signed({1'b0, regs.outer_x}) - $signed({1'b0, regs.corner_x});
  assign dyo = $signed({1'b0, regs.outer_y}) - $signed({1'b0, regs.corner_y});
  always_ff @(posedge clk) begin
    if (en) begin
      cymx2 <= regs.corner_y * mx1;
      cxmy2 <= regs.corner_x * my1;
      qa2   <= dxo * $signed({1'b0, my1});
      qb2   <= dyo * $signed({1'b0, mx1});
      la2   <= regs.corner_y * regs.outer_x;
      lb2   <= regs.corner_x * regs.outer_y;
      mx2 <= mx1;
      my2 <= my1;
      nx2 <= nx1;
      ny2 <= ny1;
    end
  end

  // stage 3: octagon side and scale decision
  logic sel;
  logic signed [17:0] dsel;
  logic [13:0] lsel;
  logic [14:0] d3;
  logic [13:0] l3;
  logic sc3;
  logic [7:0] mx3, my3;
  logic nx3, ny3;
  assign sel  = cxmy2 <= cymx2;
  assign dsel = sel ? $signed({3'b0, cymx2}) + 18'(qa2)
                    : $signed({3'b0, cxmy2}) + 18'(qb2);
  assign lsel = sel ? la2 : lb2;
  always_ff @(posedge clk) begin
    if (en) begin
      d3  <= dsel[14:0];
      l3  <= lsel;
      sc3 <= $signed({4'b0, lsel}) < dsel;
      mx3 <= mx2;
      my3 <= my2;
      nx3 <= nx2;
      ny3 <= ny2;
    end
  end

  // stage 4: numerators
  logic [21:0] rx [0:N];
  logic [21:0] ry [0:N];
  logic [N-1:0] qx [0:N];
  logic [N-1:0] qy [0:N];
  logic [14:0] dd [0:N];
  logic sc [0:N];
  logic [7:0] mx [0:N];
  logic [7:0] my [0:N];
  logic nx [0:N];
  logic ny [0:N];
  always_ff @(posedge clk) begin
    if (en) begin
      rx[0] <= l3 * mx3;
      ry[0] <= l3 * my3;
      qx[0] <= '0;
      qy[0] <= '0;
      dd[0] <= d3;
      sc[0] <= sc3;
      mx[0] <= mx3;
      my[0] <= my3;
      nx[0] <= nx3;
      ny[0] <= ny3;
    end
  end

  // divider: one quotient bit per stage
  for (genvar j = 0; j < N; j++) begin : g_div
    localparam int K = N - 1 - j;
    logic [22:0] dsh;
    assign dsh = 23'(dd[j]) << K;
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rx[j]} >= dsh) begin
          rx[j+1] <= 22'({1'b0, rx[j]} - dsh);
          qx[j+1] <= qx[j] | (N'(1) << K);
        end else begin
          rx[j+1] <= rx[j];
          qx[j+1] <= qx[j];
        end
        if ({1'b0, ry[j]} >= dsh) begin
          ry[j+1] <= 22'({1'b0, ry[j]} - dsh);
          qy[j+1] <= qy[j] | (N'(1) << K);
        end else begin
          ry[j+1] <= ry[j];
          qy[j+1] <= qy[j];
        end
        dd[j+1] <= dd[j];
        sc[j+1] <= sc[j];
        mx[j+1] <= mx[j];
        my[j+1] <= my[j];
        nx[j+1] <= nx[j];
        ny[j+1] <= ny[j];
      end
    end
  end

  // final stage: pick scaled value, restore sign
  logic [7:0] vx, vy;
  assign vx = sc[N] ? 8'(qx[N]) : mx[N];
  assign vy = sc[N] ? 8'(qy[N]) : my[N];
  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= nx[N] ? $signed(8'(-vx)) : $signed(vx);
      y_out <= ny[N] ? $signed(8'(-vy)) : $signed(vy);
    end
  end
endmodule

// File: design/pad_stick_trigger_clamp.sv
// top level of the pad stick and trigger conditioner
// depends on psc_pkg, psc_ifs, psc_cfg, psc_stick and assert_macros.svh
`timescale 1ns / 1ps
// Conditions one controller report per request: stick dead zone and octagon
// clamp, trigger floor and ceiling, error reports passed unchanged. One report
// is accepted every cycle unless a valid result is not taken, which holds the
// whole pipeline; results pass magnitude, products, side select, numerators,
// the seven-stage bit-per-cycle octagon scaling divider, and sign restore.
`include "assert_macros.svh"
module pad_stick_trigger_clamp (
  input  logic clk,
  input  logic rst,
  psc_cfg_if.sink cfg,
  psc_in_if.sink  din,
  psc_out_if.source dout
);
  localparam int S = psc_pkg::Stages;

  psc_pkg::cfg_t regs;
  logic en;
  logic [S-1:0] vld;

  psc_cfg u_cfg (.clk(clk), .rst(rst), .cfg(cfg), .regs(regs));

  assign en = !vld[S-1] || dout.ready;
  assign din.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S-2:0], din.valid};
    end
  end

  logic signed [7:0] mxo, myo, sxo, syo;
  psc_stick u_main (.clk(clk), .en(en), .regs(regs), .x(din.main_x), .y(din.main_y),
                    .x_out(mxo), .y_out(myo));
  psc_stick u_sub (.clk(clk), .en(en), .regs(regs), .x(din.sub_x), .y(din.sub_y),
                   .x_out(sxo), .y_out(syo));

  function automatic logic [7:0] shape_trig(input logic [7:0] t, input logic [7:0] fl,
                                            input logic [7:0] ce);
    logic [7:0] c;
    c = (ce < t) ? ce : t;
    return (t <= fl) ? 8'd0 : c - fl;
  endfunction

  // payload delay line
  logic        err [0:S-1];
  logic [7:0]  raw [0:S-1][0:5];
  logic [7:0]  lt [0:S-1];
  logic [7:0]  rt [0:S-1];
  always_ff @(posedge clk) begin
    if (en) begin
      err[0] <= din.pad_error;
      raw[0][0] <= din.main_x;
      raw[0][1] <= din.main_y;
      raw[0][2] <= din.sub_x;
      raw[0][3] <= din.sub_y;
      raw[0][4] <= din.left_trigger;
      raw[0][5] <= din.right_trigger;
      lt[0] <= shape_trig(din.left_trigger, regs.trigger_floor, regs.trigger_ceiling);
      rt[0] <= shape_trig(din.right_trigger, regs.trigger_floor, regs.trigger_ceiling);
      for (int i = 1; i < S; i++) begin
        err[i] <= err[i-1];
        raw[i] <= raw[i-1];
        lt[i]  <= lt[i-1];
        rt[i]  <= rt[i-1];
      end
    end
  end

  assign dout.valid = vld[S-1];
  assign dout.main_x_out = err[S-1] ? $signed(raw[S-1][0]) : mxo;
  assign dout.main_y_out = err[S-1] ? $signed(raw[S-1][1]) : myo;
  assign dout.sub_x_out  = err[S-1] ? $signed(raw[S-1][2]) : sxo;
  assign dout.sub_y_out  = err[S-1] ? $signed(raw[S-1][3]) : syo;
  assign dout.left_trigger_out  = err[S-1] ? raw[S-1][4] : lt[S-1];
  assign dout.right_trigger_out = err[S-1] ? raw[S-1][5] : rt[S-1];

  `ASSERT_NEXT(a_enter, clk, rst, din.valid && din.ready, vld[0])
  `ASSERT_NEXT(a_hold, clk, rst, vld[0] && !en, vld[0])
  `ASSERT_NEXT(a_drain, clk, rst, dout.valid && dout.ready && !vld[S-2], !dout.valid)
endmodule

// File: verif/psc_checker.sv
// report checker: watches the request channels, predicts each conditioned report
// depends on psc_pkg and psc_ifs
`timescale 1ns / 1ps
module psc_checker (
  input  logic clk,
  input  logic rst,
  psc_cfg_if.sink cfg,
  psc_in_if.sink  din,
  psc_out_if.sink dout,
  output int      fail_count,
  output int      pending,
  output int      reports_checked
);
  typedef struct {
    logic signed [7:0] mx;
    logic signed [7:0] my;
    logic signed [7:0] sx;
    logic signed [7:0] sy;
    logic [7:0] lt;
    logic [7:0] rt;
  } report_t;

  psc_pkg::cfg_t shadow;
  report_t conditioned_q[$];

  assign pending = conditioned_q.size();

  function automatic longint strip_play(longint mag);
    return (mag <= longint'(shadow.dead_zone)) ? 0 : mag - longint'(shadow.dead_zone);
  endfunction

  function automatic void shape_stick(input logic signed [7:0] rx, input logic signed [7:0] ry,
                                      output logic signed [7:0] ox,
                                      output logic signed [7:0] oy);
    longint x, y, mx, my, cx, cy, d, lim;
    logic negx, negy;
    x = rx;
    y = ry;
    negx = x < 0;
    negy = y < 0;
    mx = strip_play(negx ? -x : x);
    my = strip_play(negy ? -y : y);
    cx = shadow.corner_x;
    cy = shadow.corner_y;
    if (mx == 0 && my == 0) begin
      ox = 0;
      oy = 0;
      return;
    end
    if (cx * my <= cy * mx) begin
      d = cy * mx + (longint'(shadow.outer_x) - cx) * my;
      lim = cy * longint'(shadow.outer_x);
    end else begin
      d = cx * my + (longint'(shadow.outer_y) - cy) * mx;
      lim = cx * longint'(shadow.outer_y);
    end
    if (lim < d) begin
      mx = lim * mx / d;
      my = lim * my / d;
    end
    ox = 8'(negx ? -mx : mx);
    oy = 8'(negy ? -my : my);
  endfunction

  function automatic logic [7:0] shape_trigger(logic [7:0] t);
    logic [7:0] c;
    if (t <= shadow.trigger_floor) return 8'd0;
    c = (shadow.trigger_ceiling < t) ? shadow.trigger_ceiling : t;
    return c - shadow.trigger_floor;
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    report_t r;
    if (rst) begin
      shadow <= '{7'd15, 7'd74, 7'd74, 7'd52, 7'd52, 8'd40, 8'd210};
      fail_count <= 0;
      reports_checked <= 0;
      conditioned_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (psc_pkg::reg_idx_t'(cfg.index))
          psc_pkg::REG_DEAD_ZONE:       shadow.dead_zone <= cfg.data[6:0];
          psc_pkg::REG_OUTER_X:         shadow.outer_x <= cfg.data[6:0];
          psc_pkg::REG_OUTER_Y:         shadow.outer_y <= cfg.data[6:0];
          psc_pkg::REG_CORNER_X:        shadow.corner_x <= cfg.data[6:0];
          psc_pkg::REG_CORNER_Y:        shadow.corner_y <= cfg.data[6:0];
          psc_pkg::REG_TRIGGER_FLOOR:   shadow.trigger_floor <= cfg.data;
          psc_pkg::REG_TRIGGER_CEILING: shadow.trigger_ceiling <= cfg.data;
          default: ;
        endcase
      end
      if (din.valid && din.ready) begin
        if (din.pad_error) begin
          r = '{din.main_x, din.main_y, din.sub_x, din.sub_y, din.left_trigger,
                din.right_trigger};
        end else begin
          shape_stick(din.main_x, din.main_y, r.mx, r.my);
          shape_stick(din.sub_x, din.sub_y, r.sx, r.sy);
          r.lt = shape_trigger(din.left_trigger);
          r.rt = shape_trigger(din.right_trigger);
        end
        conditioned_q.push_back(r);
      end
      if (dout.valid && dout.ready) begin
        if (conditioned_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          r = conditioned_q.pop_front();
          check_field("main_x_out", r.mx, dout.main_x_out);
          check_field("main_y_out", r.my, dout.main_y_out);
          check_field("sub_x_out", r.sx, dout.sub_x_out);
          check_field("sub_y_out", r.sy, dout.sub_y_out);
          check_field("left_trigger_out", r.lt, dout.left_trigger_out);
          check_field("right_trigger_out", r.rt, dout.right_trigger_out);
          reports_checked++;
        end
      end
    end
  end
endmodule

// File: verif/tb_pad_stick_trigger_clamp.sv
// top of the conditioner testbench: clock, reset, register writes and report stimulus
// depends on psc_pkg, psc_ifs, psc_checker and the block itself
`timescale 1ns / 1ps
module tb_pad_stick_trigger_clamp;
  localparam int Latency = psc_pkg::Stages;
  localparam longint CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  longint cycles = 0;
  int fail_count, pending, reports_checked;
  int stall_mode = 0;

  psc_cfg_if cfg ();
  psc_in_if  din ();
  psc_out_if dout ();

  pad_stick_trigger_clamp DUT (.clk(clk), .rst(rst), .cfg(cfg.sink), .din(din.sink),
                               .dout(dout.source));
  psc_checker checker_i (.clk(clk), .rst(rst), .cfg(cfg.sink), .din(din.sink),
                         .dout(dout.sink), .fail_count(fail_count), .pending(pending),
                         .reports_checked(reports_checked));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** pad_stick_trigger_clamp: FAILED **");
      $finish;
    end
  end

  // receiver stall pattern, mode changes per phase
  always @(negedge clk) begin
    case (stall_mode)
      0: dout.ready <= 1'b1;
      1: dout.ready <= ($urandom_range(0, 3) != 0);
      2: dout.ready <= ($urandom_range(0, 3) == 0);
      default: dout.ready <= cycles[3];
    endcase
  end

  initial begin
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    din.valid = 1'b0;
    din.pad_error = 1'b0;
    {din.main_x, din.main_y, din.sub_x, din.sub_y} = '0;
    din.left_trigger = '0;
    din.right_trigger = '0;
    dout.ready = 1'b0;
  end

  task automatic write_reg(psc_pkg::reg_idx_t idx, logic [7:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  int burst_left = 0;

  task automatic send(logic e, logic [7:0] mx, logic [7:0] my, logic [7:0] sx,
                      logic [7:0] sy, logic [7:0] lt, logic [7:0] rt);
    if (burst_left == 0) begin
      din.valid <= 1'b0;
      repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    din.valid <= 1'b1;
    din.pad_error <= e;
    din.main_x <= mx;
    din.main_y <= my;
    din.sub_x <= sx;
    din.sub_y <= sy;
    din.left_trigger <= lt;
    din.right_trigger <= rt;
    do @(posedge clk); while (!din.ready);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 8'h80;
      1: return 8'h7f;
      2: return 8'(int'($urandom_range(0, 40)) - 20);
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      send($urandom_range(0, 7) == 0, rand_axis(), rand_axis(), rand_axis(), rand_axis(),
           8'($urandom), 8'($urandom));
    din.valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings
    send(0, 8'h00, 8'h00, 8'h0f, 8'hf1, 8'd0, 8'd40);
    send(0, 8'h7f, 8'h7f, 8'h80, 8'h80, 8'd41, 8'd255);
    send(0, 8'h7f, 8'h00, 8'h00, 8'h80, 8'd210, 8'd211);
    send(0, 8'h10, 8'hf0, 8'h30, 8'h50, 8'd128, 8'd1);
    send(1, 8'h80, 8'h7f, 8'h12, 8'hff, 8'd255, 8'd0);
    send(1, 8'h00, 8'h80, 8'h7f, 8'h01, 8'd7, 8'd200);
    din.valid <= 1'b0;
    // sender holds until everything drains
    drain();

    // no dead zone, corner x beyond outer x, ceiling below floor
    write_reg(psc_pkg::REG_DEAD_ZONE, 8'h80);
    write_reg(psc_pkg::REG_OUTER_X, 8'd1);
    write_reg(psc_pkg::REG_OUTER_Y, 8'd127);
    write_reg(psc_pkg::REG_CORNER_X, 8'd127);
    write_reg(psc_pkg::REG_CORNER_Y, 8'd1);
    write_reg(psc_pkg::REG_TRIGGER_FLOOR, 8'd255);
    write_reg(psc_pkg::REG_TRIGGER_CEILING, 8'd0);
    write_reg(psc_pkg::reg_idx_t'(3'd7), 8'd99);
    send(0, 8'h80, 8'h80, 8'h80, 8'h00, 8'd255, 8'd254);
    send(0, 8'h7f, 8'h80, 8'h01, 8'hff, 8'd0, 8'd128);
    din.valid <= 1'b0;
    drain();
    write_reg(psc_pkg::REG_TRIGGER_FLOOR, 8'd200);
    write_reg(psc_pkg::REG_TRIGGER_CEILING, 8'd10);
    send(0, 8'h80, 8'h7f, 8'h40, 8'hc0, 8'd201, 8'd255);
    din.valid <= 1'b0;
    random_phase(250);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      stall_mode = phase % 4;
      write_reg(psc_pkg::REG_DEAD_ZONE, phase == 5 ? 8'd127 : 8'($urandom_range(0, 40)));
      write_reg(psc_pkg::REG_OUTER_X, phase == 0 ? 8'd127 : 8'($urandom_range(1, 127)));
      write_reg(psc_pkg::REG_OUTER_Y, 8'($urandom_range(1, 127)));
      write_reg(psc_pkg::REG_CORNER_X, 8'($urandom_range(1, 127)));
      write_reg(psc_pkg::REG_CORNER_Y, phase == 0 ? 8'd127 : 8'($urandom_range(1, 127)));
      write_reg(psc_pkg::REG_TRIGGER_FLOOR, phase == 1 ? 8'd0 : 8'($urandom));
      write_reg(psc_pkg::REG_TRIGGER_CEILING, phase == 1 ? 8'd255 : 8'($urandom));
      random_phase(260);
      drain();
    end

    $display("covered %0d reports over nine register settings with bursty sender",
             reports_checked);
    $display("and varied receiver stalls, error pass-through and extreme registers");
    if (fail_count == 0)
      $display("** pad_stick_trigger_clamp: PASSED **");
    else
      $display("** pad_stick_trigger_clamp: FAILED **");
    $finish;
  end
endmodule
